@@ rtl/spla_pkg.sv @@
// Shared definitions for the session pool allocator: field widths, request,
// status and register codes, sequencer states and the control bundles.
// No dependencies; every other file of the block imports this package.
package spla_pkg;

   // Default sizes of the slot pool and the worker set.
   localparam int MAX_SLOTS_DEF   = 64;
   localparam int MAX_WORKERS_DEF = 8;

   // Fixed widths of the request, response and register fields.
   localparam int REQ_TYPE_W    = 2;
   localparam int SLOT_PORT_W   = 6;
   localparam int STATUS_W      = 3;
   localparam int WORKER_PORT_W = 3;
   localparam int CSR_INDEX_W   = 2;
   localparam int CSR_DATA_W    = 4;
   localparam int NUM_WORKERS_W = 4;
   localparam int SESSIONS_W    = 4;

   // Per-worker load counters saturate at their top value.
   localparam int LOAD_W = 7;
   localparam logic [LOAD_W-1:0] LOAD_MAX = LOAD_W'(127);

   // The idle slot search looks at one group of this many slots per cycle.
   localparam int SCAN_CHUNK  = 8;
   localparam int CHUNK_POS_W = 3;

   typedef enum logic [REQ_TYPE_W-1:0] {
      REQ_INIT  = 2'd0,
      REQ_START = 2'd1,
      REQ_OPEN  = 2'd2,
      REQ_CLOSE = 2'd3
   } req_code_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK       = 3'd0,
      STAT_NOT_INIT = 3'd1,
      STAT_NO_IDLE  = 3'd2,
      STAT_INVALID  = 3'd3,
      STAT_NOT_OPEN = 3'd4
   } status_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_ACCEL       = 2'd0,
      CSR_NUM_WORKERS = 2'd1,
      CSR_SESSIONS    = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      FSM_IDLE,
      FSM_DECODE,
      FSM_INIT_POOL,
      FSM_INIT_FILL,
      FSM_SCAN,
      FSM_CLOSE_RD,
      FSM_FINISH
   } fsm_type;

   // Commands from the sequencer to the slot pool.
   typedef struct packed {
      logic init_fill;
      logic scan_start;
      logic open_commit;
      logic close_commit;
   } pool_ctrl_type;

   // Commands from the sequencer to the worker load unit.
   typedef struct packed {
      logic clear;
      logic scan_start;
      logic inc;
      logic dec;
   } load_ctrl_type;

endpackage

@@ rtl/spla_load.sv @@
// Worker load counters and the iterative least-loaded search, which runs one
// shared compare over the active workers, one worker per cycle.
// Depends on spla_pkg.
module spla_load #(
   parameter int  MAX_WORKERS = spla_pkg::MAX_WORKERS_DEF,
   localparam int WRK_W       = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1,
   localparam int CNT_W       = $clog2(MAX_WORKERS + 1)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  spla_pkg::load_ctrl_type ctrl,
   input  logic [CNT_W-1:0]        active_workers,
   input  logic [WRK_W-1:0]        dec_worker,
   output logic                    busy,
   output logic [WRK_W-1:0]        best_worker
);
   import spla_pkg::*;

   logic [LOAD_W-1:0] load_ff [MAX_WORKERS];
   logic [LOAD_W-1:0] load_in [MAX_WORKERS];
   logic              busy_ff, busy_in;
   logic [WRK_W-1:0]  idx_ff, idx_in;
   logic [WRK_W-1:0]  best_ff, best_in;
   logic [LOAD_W-1:0] best_load_ff, best_load_in;
   logic [LOAD_W-1:0] cand_load;
   logic [CNT_W-1:0]  idx_next;

   assign cand_load   = load_ff[idx_ff];
   assign idx_next    = CNT_W'(idx_ff) + CNT_W'(1);
   assign busy        = busy_ff;
   assign best_worker = best_ff;

   // Search: worker 0 is the first candidate; a strictly lower load replaces it,
   // so the lowest index wins a tie.
   always_comb begin
      busy_in      = busy_ff;
      idx_in       = idx_ff;
      best_in      = best_ff;
      best_load_in = best_load_ff;
      if (ctrl.scan_start) begin
         idx_in       = WRK_W'(1);
         best_in      = '0;
         best_load_in = load_ff[0];
         busy_in      = (active_workers > CNT_W'(1));
      end else if (busy_ff) begin
         if (cand_load < best_load_ff) begin
            best_in      = idx_ff;
            best_load_in = cand_load;
         end
         if (idx_next >= active_workers) begin
            busy_in = 1'b0;
         end else begin
            idx_in = WRK_W'(idx_next);
         end
      end
   end

   // Counter updates: each counter looks only at its own value.
   always_comb begin
      for (int j = 0; j < MAX_WORKERS; j++) begin
         load_in[j] = load_ff[j];
         if (ctrl.clear) begin
            load_in[j] = '0;
         end else if (ctrl.inc && (best_ff == WRK_W'(j)) && (load_ff[j] != LOAD_MAX)) begin
            load_in[j] = load_ff[j] + LOAD_W'(1);
         end else if (ctrl.dec && (dec_worker == WRK_W'(j)) && (load_ff[j] != '0)) begin
            load_in[j] = load_ff[j] - LOAD_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         for (int j = 0; j < MAX_WORKERS; j++) begin
            load_ff[j] <= '0;
         end
      end else begin
         busy_ff <= busy_in;
         load_ff <= load_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      best_ff      <= best_in;
      best_load_ff <= best_load_in;
   end

endmodule

@@ rtl/spla_pool.sv @@
// Slot pool: idle and open flags per slot, the worker binding memory and the
// lowest idle slot search, which looks at one group of eight slots per cycle.
// Depends on spla_pkg.
module spla_pool #(
   parameter int  MAX_SLOTS   = spla_pkg::MAX_SLOTS_DEF,
   parameter int  MAX_WORKERS = spla_pkg::MAX_WORKERS_DEF,
   localparam int SLOT_W      = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1,
   localparam int WRK_W       = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1,
   localparam int POOL_W      = $clog2(MAX_SLOTS + 1)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  spla_pkg::pool_ctrl_type ctrl,
   input  logic [POOL_W-1:0]       pool_size,
   input  logic [SLOT_W-1:0]       access_slot,
   input  logic [WRK_W-1:0]        bind_worker,
   output logic                    busy,
   output logic                    found,
   output logic [SLOT_W-1:0]       found_slot,
   output logic                    access_open,
   output logic [WRK_W-1:0]        access_worker
);
   import spla_pkg::*;

   localparam int NUM_CHUNKS = (MAX_SLOTS + SCAN_CHUNK - 1) / SCAN_CHUNK;
   localparam int PAD_SLOTS  = NUM_CHUNKS * SCAN_CHUNK;
   localparam int CH_W       = (NUM_CHUNKS > 1) ? $clog2(NUM_CHUNKS) : 1;

   logic [MAX_SLOTS-1:0]   idle_ff, idle_in;
   logic [MAX_SLOTS-1:0]   open_ff, open_in;
   logic [PAD_SLOTS-1:0]   idle_pad;
   logic [SCAN_CHUNK-1:0]  chunk_bits;
   logic                   chunk_hit;
   logic [CHUNK_POS_W-1:0] chunk_pos;
   logic [CH_W-1:0]        chunk_ff, chunk_in;
   logic                   busy_ff, busy_in;
   logic                   found_ff, found_in;
   logic [SLOT_W-1:0]      found_slot_ff, found_slot_in;
   logic [WRK_W-1:0]       worker_mem [MAX_SLOTS];
   logic [WRK_W-1:0]       rd_data_ff;

   assign idle_pad      = PAD_SLOTS'(idle_ff);
   assign chunk_bits    = idle_pad[chunk_ff*SCAN_CHUNK +: SCAN_CHUNK];
   assign busy          = busy_ff;
   assign found         = found_ff;
   assign found_slot    = found_slot_ff;
   assign access_open   = open_ff[access_slot];
   assign access_worker = rd_data_ff;

   // Lowest set bit of the current group.
   always_comb begin
      chunk_hit = 1'b0;
      chunk_pos = '0;
      for (int b = SCAN_CHUNK - 1; b >= 0; b--) begin
         if (chunk_bits[b]) begin
            chunk_hit = 1'b1;
            chunk_pos = CHUNK_POS_W'(b);
         end
      end
   end

   // Group sequencer: stops at the first group with an idle slot, or after the last group.
   always_comb begin
      busy_in       = busy_ff;
      chunk_in      = chunk_ff;
      found_in      = found_ff;
      found_slot_in = found_slot_ff;
      if (ctrl.scan_start) begin
         busy_in  = 1'b1;
         chunk_in = '0;
         found_in = 1'b0;
      end else if (busy_ff) begin
         if (chunk_hit) begin
            found_in      = 1'b1;
            found_slot_in = SLOT_W'({chunk_ff, chunk_pos});
            busy_in       = 1'b0;
         end else if (chunk_ff == CH_W'(NUM_CHUNKS - 1)) begin
            busy_in = 1'b0;
         end else begin
            chunk_in = chunk_ff + CH_W'(1);
         end
      end
   end

   // Slot flags: init rebuilds the pool, open and close move one slot.
   always_comb begin
      idle_in = idle_ff;
      open_in = open_ff;
      if (ctrl.init_fill) begin
         for (int i = 0; i < MAX_SLOTS; i++) begin
            idle_in[i] = (POOL_W'(i) < pool_size);
         end
         open_in = '0;
      end else if (ctrl.open_commit) begin
         idle_in[found_slot_ff] = 1'b0;
         open_in[found_slot_ff] = 1'b1;
      end else if (ctrl.close_commit) begin
         idle_in[access_slot] = 1'b1;
         open_in[access_slot] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idle_ff  <= '0;
         open_ff  <= '0;
         busy_ff  <= 1'b0;
         found_ff <= 1'b0;
      end else begin
         idle_ff  <= idle_in;
         open_ff  <= open_in;
         busy_ff  <= busy_in;
         found_ff <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      chunk_ff      <= chunk_in;
      found_slot_ff <= found_slot_in;
   end

   // Worker binding memory: written by a granted open, read through an output register.
   always_ff @(posedge clock) begin
      if (ctrl.open_commit) begin
         worker_mem[found_slot_ff] <= bind_worker;
      end
      rd_data_ff <= worker_mem[access_slot];
   end

endmodule

@@ rtl/session_pool_least_loaded_allocator_unit.sv @@
// Session pool allocator with least-loaded worker binding.
// Request channel (req_valid, req_stall, req_type, req_slot_in) carries init,
// start, open and close requests; one response (rsp_status, rsp_slot_out,
// rsp_worker_out) follows every request, in order, on rsp_valid / rsp_stall.
// The csr channel writes accel_requested (0), num_workers (1) and
// sessions_per_worker (2); it is always ready and takes effect at next init.
// One request is worked on at a time; req_stall is high from acceptance until
// the response is loaded into the output register. Each request is decoded,
// then finished, where the response is loaded; init adds the pool latch and
// fill steps, close adds the binding read, and open waits in the scan step for
// the slot search, which stops at the first eight-slot group with an idle slot
// (at most 8 groups for 64 slots), and the worker search over the active
// workers. The slot search and the worker search run side by side.
// The next request can be taken in the cycle after the response is registered.
// A stalled response holds in the output register; the block finishes the
// current request and waits for the register to free up.
// Reset clears the pool and all loads, leaves the block uninitialized and
// sets the registers to accel off, one worker, eight slots per worker.
module session_pool_least_loaded_allocator_unit #(
   parameter int MAX_SLOTS   = spla_pkg::MAX_SLOTS_DEF,
   parameter int MAX_WORKERS = spla_pkg::MAX_WORKERS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [spla_pkg::REQ_TYPE_W-1:0]    req_type,
   input  logic [spla_pkg::SLOT_PORT_W-1:0]   req_slot_in,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [spla_pkg::STATUS_W-1:0]      rsp_status,
   output logic [spla_pkg::SLOT_PORT_W-1:0]   rsp_slot_out,
   output logic [spla_pkg::WORKER_PORT_W-1:0] rsp_worker_out,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [spla_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [spla_pkg::CSR_DATA_W-1:0]    csr_data
);
   import spla_pkg::*;

   localparam int SLOT_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
   localparam int WRK_W  = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
   localparam int CNT_W  = $clog2(MAX_WORKERS + 1);
   localparam int POOL_W = $clog2(MAX_SLOTS + 1);
   localparam int CALC_W = $clog2(MAX_WORKERS * ((1 << SESSIONS_W) - 1) + MAX_SLOTS + 1);
   localparam logic [NUM_WORKERS_W-1:0] NUM_WORKERS_RESET = NUM_WORKERS_W'(1);
   localparam logic [SESSIONS_W-1:0]    SESSIONS_RESET    = SESSIONS_W'(8);

   fsm_type                     state_ff, state_in;
   logic                        accel_ff;
   logic [NUM_WORKERS_W-1:0]    nworkers_ff;
   logic [SESSIONS_W-1:0]       sessions_ff;
   logic                        ready_ff, ready_in;
   logic [CNT_W-1:0]            active_ff, active_in;
   logic [POOL_W-1:0]           pool_ff, pool_in;
   logic                        latch_pool;
   req_code_type                req_code_ff;
   logic [SLOT_PORT_W-1:0]      slot_req_ff;
   status_type                  res_status_ff, res_status_in;
   logic [SLOT_PORT_W-1:0]      res_slot_ff, res_slot_in;
   logic [WORKER_PORT_W-1:0]    res_worker_ff, res_worker_in;
   logic                        out_load;
   logic                        rsp_valid_ff, rsp_valid_in;
   status_type                  rsp_status_ff;
   logic [SLOT_PORT_W-1:0]      rsp_slot_ff;
   logic [WORKER_PORT_W-1:0]    rsp_worker_ff;
   logic                        req_accept;
   logic                        slot_in_range;
   logic [CALC_W-1:0]           nw_ext, w_sat, prod, pool_calc;
   pool_ctrl_type               pool_ctrl;
   load_ctrl_type               load_ctrl;
   logic                        pool_busy, pool_found, access_open;
   logic [SLOT_W-1:0]           found_slot;
   logic [WRK_W-1:0]            access_worker, best_worker;
   logic                        load_busy;

   assign req_stall      = (state_ff != FSM_IDLE);
   assign req_accept     = req_valid && !req_stall;
   assign csr_ready      = 1'b1;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_slot_out   = rsp_slot_ff;
   assign rsp_worker_out = rsp_worker_ff;
   assign slot_in_range  = (32'(slot_req_ff) < 32'(MAX_SLOTS));

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         accel_ff    <= 1'b0;
         nworkers_ff <= NUM_WORKERS_RESET;
         sessions_ff <= SESSIONS_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            CSR_ACCEL:       accel_ff    <= csr_data[0];
            CSR_NUM_WORKERS: nworkers_ff <= csr_data;
            CSR_SESSIONS:    sessions_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // Pool size and active worker count from the registers, latched at init.
   always_comb begin
      nw_ext = CALC_W'(nworkers_ff);
      if (nw_ext == '0) begin
         w_sat = CALC_W'(1);
      end else if (nw_ext > CALC_W'(MAX_WORKERS)) begin
         w_sat = CALC_W'(MAX_WORKERS);
      end else begin
         w_sat = nw_ext;
      end
      prod = w_sat * CALC_W'(sessions_ff);
      if (nw_ext == '0) begin
         pool_calc = '0;
      end else if (prod > CALC_W'(MAX_SLOTS)) begin
         pool_calc = CALC_W'(MAX_SLOTS);
      end else begin
         pool_calc = prod;
      end
      pool_in   = POOL_W'(pool_calc);
      active_in = CNT_W'(w_sat);
   end

   // Sequencer: next state, unit commands and the pending result.
   always_comb begin
      state_in      = state_ff;
      ready_in      = ready_ff;
      latch_pool    = 1'b0;
      pool_ctrl     = '0;
      load_ctrl     = '0;
      res_status_in = res_status_ff;
      res_slot_in   = res_slot_ff;
      res_worker_in = res_worker_ff;
      out_load      = 1'b0;
      case (state_ff)
         FSM_IDLE: begin
            if (req_accept) begin
               state_in = FSM_DECODE;
            end
         end
         FSM_DECODE: begin
            res_status_in = STAT_OK;
            res_slot_in   = '0;
            res_worker_in = '0;
            state_in      = FSM_FINISH;
            case (req_code_ff)
               REQ_INIT: begin
                  if (accel_ff) begin
                     res_status_in = STAT_INVALID;
                     ready_in      = 1'b0;
                  end else begin
                     state_in = FSM_INIT_POOL;
                  end
               end
               REQ_START: begin
                  if (!ready_ff) begin
                     res_status_in = STAT_NOT_INIT;
                  end
               end
               REQ_OPEN: begin
                  if (!ready_ff) begin
                     res_status_in = STAT_NOT_INIT;
                  end else begin
                     pool_ctrl.scan_start = 1'b1;
                     load_ctrl.scan_start = 1'b1;
                     state_in             = FSM_SCAN;
                  end
               end
               REQ_CLOSE: begin
                  if (!slot_in_range || !access_open) begin
                     res_status_in = STAT_NOT_OPEN;
                  end else begin
                     state_in = FSM_CLOSE_RD;
                  end
               end
               default: ;
            endcase
         end
         FSM_INIT_POOL: begin
            latch_pool = 1'b1;
            state_in   = FSM_INIT_FILL;
         end
         FSM_INIT_FILL: begin
            pool_ctrl.init_fill = 1'b1;
            load_ctrl.clear     = 1'b1;
            ready_in            = 1'b1;
            state_in            = FSM_FINISH;
         end
         FSM_SCAN: begin
            if (!pool_busy && !load_busy) begin
               state_in = FSM_FINISH;
               if (!pool_found) begin
                  res_status_in = STAT_NO_IDLE;
               end else begin
                  pool_ctrl.open_commit = 1'b1;
                  load_ctrl.inc         = 1'b1;
                  res_slot_in           = SLOT_PORT_W'(found_slot);
                  res_worker_in         = WORKER_PORT_W'(best_worker);
               end
            end
         end
         FSM_CLOSE_RD: begin
            pool_ctrl.close_commit = 1'b1;
            load_ctrl.dec          = 1'b1;
            res_worker_in          = WORKER_PORT_W'(access_worker);
            state_in               = FSM_FINISH;
         end
         FSM_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               out_load = 1'b1;
               state_in = FSM_IDLE;
            end
         end
         default: state_in = FSM_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = out_load || (rsp_valid_ff && rsp_stall);
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FSM_IDLE;
         ready_ff     <= 1'b0;
         active_ff    <= CNT_W'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ready_ff     <= ready_in;
         rsp_valid_ff <= rsp_valid_in;
         if (latch_pool) begin
            active_ff <= active_in;
         end
      end
   end

   // Request, pool size, pending result and output payload.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         req_code_ff <= req_code_type'(req_type);
         slot_req_ff <= req_slot_in;
      end
      if (latch_pool) begin
         pool_ff <= pool_in;
      end
      res_status_ff <= res_status_in;
      res_slot_ff   <= res_slot_in;
      res_worker_ff <= res_worker_in;
      if (out_load) begin
         rsp_status_ff <= res_status_ff;
         rsp_slot_ff   <= res_slot_ff;
         rsp_worker_ff <= res_worker_ff;
      end
   end

   spla_pool #(
      .MAX_SLOTS   (MAX_SLOTS),
      .MAX_WORKERS (MAX_WORKERS)
   ) u_pool (
      .clock         (clock),
      .reset         (reset),
      .ctrl          (pool_ctrl),
      .pool_size     (pool_ff),
      .access_slot   (SLOT_W'(slot_req_ff)),
      .bind_worker   (best_worker),
      .busy          (pool_busy),
      .found         (pool_found),
      .found_slot    (found_slot),
      .access_open   (access_open),
      .access_worker (access_worker)
   );

   spla_load #(
      .MAX_WORKERS (MAX_WORKERS)
   ) u_load (
      .clock          (clock),
      .reset          (reset),
      .ctrl           (load_ctrl),
      .active_workers (active_ff),
      .dec_worker     (access_worker),
      .busy           (load_busy),
      .best_worker    (best_worker)
   );

endmodule

@@ rtl/spla_checker.sv @@
// Port-level checks for the session pool allocator, bound to the top level.
// Depends on spla_pkg and session_pool_least_loaded_allocator_unit.
module spla_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_stall,
   input logic                               rsp_valid,
   input logic                               rsp_stall,
   input logic [spla_pkg::STATUS_W-1:0]      rsp_status,
   input logic [spla_pkg::SLOT_PORT_W-1:0]   rsp_slot_out,
   input logic [spla_pkg::WORKER_PORT_W-1:0] rsp_worker_out
);
   import spla_pkg::*;

   // A stalled response stays put.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_status)
         && $stable(rsp_slot_out) && $stable(rsp_worker_out)))
      else $error("stalled response changed");

   // After an accepted request, req_stall stays high while the block decodes it and in the state that follows.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (req_stall ##1 req_stall))
      else $error("request channel reopened too early");

   // A failed request grants no slot and names no worker.
   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != STAT_OK)) |-> ((rsp_slot_out == '0)
         && (rsp_worker_out == '0)))
      else $error("error response carries a slot or worker");

endmodule

bind session_pool_least_loaded_allocator_unit spla_checker u_spla_checker (.*);

@@ tb/sv/session_pool_least_loaded_allocator_unit_tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for session_pool_least_loaded_allocator_unit: a scoreboard
// class predicts every response from its own copy of the pool, loads and registers.
// Depends on spla_pkg and the allocator RTL only.
module session_pool_least_loaded_allocator_unit_tb;
   import spla_pkg::*;

   localparam int POOL_SLOTS   = MAX_SLOTS_DEF;
   localparam int POOL_WORKERS = MAX_WORKERS_DEF;

   typedef struct {
      status_type                status;
      logic [SLOT_PORT_W-1:0]    slot;
      logic [WORKER_PORT_W-1:0]  worker;
   } alloc_result_type;

   // Pool predictor and in-order response checker.
   class session_pool_scoreboard_type;
      logic                     accel_mode;
      logic [NUM_WORKERS_W-1:0] worker_cfg;
      logic [SESSIONS_W-1:0]    slots_cfg;
      bit                       pool_ready;
      bit                       idle_map[POOL_SLOTS];
      bit                       open_map[POOL_SLOTS];
      logic [WORKER_PORT_W-1:0] bound_worker[POOL_SLOTS];
      logic [LOAD_W-1:0]        load[POOL_WORKERS];
      int                       live_workers;
      alloc_result_type         awaited[$];
      int                       failures;
      int                       checked;
      int                       requests;
      int                       status_seen[5];

      function new();
         accel_mode   = 1'b0;
         worker_cfg   = 4'd1;
         slots_cfg    = 4'd8;
         pool_ready   = 1'b0;
         live_workers = 1;
         foreach (idle_map[i]) begin
            idle_map[i]     = 1'b0;
            open_map[i]     = 1'b0;
            bound_worker[i] = '0;
         end
         foreach (load[i]) load[i] = '0;
         foreach (status_seen[i]) status_seen[i] = 0;
      endfunction

      function void write_reg(csr_index_type idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_ACCEL:       accel_mode = data[0];
            CSR_NUM_WORKERS: worker_cfg = data;
            CSR_SESSIONS:    slots_cfg  = data;
            default: ;
         endcase
      endfunction

      // Works out the response of one accepted request and queues it.
      function void note_request(req_code_type code, logic [SLOT_PORT_W-1:0] slot);
         alloc_result_type r;
         int w;
         int pool;
         int hit;
         int best;
         r = '{STAT_OK, '0, '0};
         requests++;
         case (code)
            REQ_INIT: begin
               if (accel_mode) begin
                  pool_ready = 1'b0;
                  r.status   = STAT_INVALID;
               end else begin
                  w = worker_cfg;
                  if (w < 1) w = 1;
                  if (w > POOL_WORKERS) w = POOL_WORKERS;
                  live_workers = w;
                  pool = (worker_cfg == 0) ? 0 : w * slots_cfg;
                  if (pool > POOL_SLOTS) pool = POOL_SLOTS;
                  foreach (open_map[i]) begin
                     open_map[i] = 1'b0;
                     idle_map[i] = (i < pool);
                  end
                  foreach (load[i]) load[i] = '0;
                  pool_ready = 1'b1;
               end
            end
            REQ_START: begin
               if (!pool_ready) r.status = STAT_NOT_INIT;
            end
            REQ_OPEN: begin
               if (!pool_ready) begin
                  r.status = STAT_NOT_INIT;
               end else begin
                  hit = -1;
                  for (int i = 0; i < POOL_SLOTS && hit < 0; i++)
                     if (idle_map[i]) hit = i;
                  if (hit < 0) begin
                     r.status = STAT_NO_IDLE;
                  end else begin
                     // Least loaded worker, lowest index on a tie.
                     best = 0;
                     for (int i = 1; i < live_workers; i++)
                        if (load[i] < load[best]) best = i;
                     idle_map[hit]     = 1'b0;
                     open_map[hit]     = 1'b1;
                     bound_worker[hit] = best[WORKER_PORT_W-1:0];
                     if (load[best] != LOAD_MAX) load[best] = load[best] + 1'b1;
                     r.slot   = hit[SLOT_PORT_W-1:0];
                     r.worker = best[WORKER_PORT_W-1:0];
                  end
               end
            end
            default: begin
               // Close works whether or not the pool is initialized.
               if (!open_map[slot]) begin
                  r.status = STAT_NOT_OPEN;
               end else begin
                  best = bound_worker[slot];
                  if (load[best] != '0) load[best] = load[best] - 1'b1;
                  open_map[slot] = 1'b0;
                  idle_map[slot] = 1'b1;
                  r.worker = best[WORKER_PORT_W-1:0];
               end
            end
         endcase
         status_seen[r.status]++;
         awaited.push_back(r);
      endfunction

      function void check_response(logic [STATUS_W-1:0] st, logic [SLOT_PORT_W-1:0] slot,
                                   logic [WORKER_PORT_W-1:0] worker);
         alloc_result_type e;
         checked++;
         if (awaited.size() == 0) begin
            failures++;
            if (failures <= 10)
               $display("%t: response with nothing pending: status %0d slot %0d worker %0d",
                        $realtime, st, slot, worker);
            return;
         end
         e = awaited.pop_front();
         if (st !== e.status || slot !== e.slot || worker !== e.worker) begin
            failures++;
            if (failures <= 10)
               $display("%t: response %0d: expected status %0d slot %0d worker %0d, got %0d %0d %0d",
                        $realtime, checked, e.status, e.slot, e.worker, st, slot, worker);
         end
      endfunction

      // Picks one currently open slot, or -1 when none is open.
      function int random_open_slot();
         int q[$];
         foreach (open_map[i]) if (open_map[i]) q.push_back(i);
         if (q.size() == 0) return -1;
         return q[$urandom_range(q.size() - 1)];
      endfunction
   endclass

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic [REQ_TYPE_W-1:0]    req_type = '0;
   logic [SLOT_PORT_W-1:0]   req_slot_in = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic [STATUS_W-1:0]      rsp_status;
   logic [SLOT_PORT_W-1:0]   rsp_slot_out;
   logic [WORKER_PORT_W-1:0] rsp_worker_out;
   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic [CSR_INDEX_W-1:0]   csr_index = '0;
   logic [CSR_DATA_W-1:0]    csr_data = '0;

   session_pool_scoreboard_type sb = new();

   int send_idle_pct = 12;
   int recv_idle_pct = 66;
   int rsp_hold_left = 0;
   int random_sent   = 0;
   int settings_run  = 0;

   session_pool_least_loaded_allocator_unit dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_type       (req_type),
      .req_slot_in    (req_slot_in),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_slot_out   (rsp_slot_out),
      .rsp_worker_out (rsp_worker_out),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Response side: random stall, or a long hold while rsp_hold_left runs down.
   initial begin
      forever begin
         @(negedge clock);
         if (rsp_hold_left > 0) begin
            rsp_stall <= 1'b1;
            rsp_hold_left--;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (rsp_valid === 1'b1 && rsp_stall === 1'b0)
         sb.check_response(rsp_status, rsp_slot_out, rsp_worker_out);
   end

   // Offers one request, with random idle cycles first, and waits for acceptance.
   task automatic send_request(req_code_type code, logic [SLOT_PORT_W-1:0] slot);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_type    <= code;
      req_slot_in <= slot;
      do @(posedge clock); while (req_stall !== 1'b0);
      sb.note_request(code, slot);
   endtask

   // Stops offering and waits until every pending response has come back.
   task automatic drain_responses();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.awaited.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (csr_ready !== 1'b1);
      sb.write_reg(idx, data);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic apply_settings(logic accel, logic [3:0] workers, logic [3:0] per_worker);
      drain_responses();
      write_reg(CSR_ACCEL, {3'b000, accel});
      write_reg(CSR_NUM_WORKERS, workers);
      write_reg(CSR_SESSIONS, per_worker);
      settings_run++;
   endtask

   // Mostly opens and closes of open slots, with some stray closes, starts and inits.
   task automatic random_request(int open_pct);
      int r;
      int s;
      r = $urandom_range(99);
      s = sb.random_open_slot();
      if (r < open_pct)
         send_request(REQ_OPEN, 6'($urandom_range(63)));
      else if (r < 88 && s >= 0)
         send_request(REQ_CLOSE, 6'(s));
      else if (r < 93 || r < 88)
         send_request(REQ_CLOSE, 6'($urandom_range(63)));
      else if (r < 98)
         send_request(REQ_START, 6'($urandom_range(63)));
      else
         send_request(REQ_INIT, 6'($urandom_range(63)));
   endtask

   // Directed checks, then ten random phases under different pool settings.
   initial begin
      int ph_accel[10]   = '{0, 0, 0, 0, 0, 0, 1, 0, 0, 0};
      int ph_workers[10] = '{4, 8, 15, 0, 3, 1, 2, 7, 0, 0};
      int ph_slots[10]   = '{3, 8, 15, 5, 0, 1, 2, 9, 0, 0};
      int ph_open[10]    = '{50, 60, 55, 45, 40, 45, 50, 50, 0, 0};
      logic [3:0] nw;
      logic [3:0] spw;
      int op;

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Requests before any init, then a one-worker pool of eight filled past full.
      send_request(REQ_START, 6'd0);
      send_request(REQ_OPEN, 6'd63);
      send_request(REQ_CLOSE, 6'd0);
      send_request(REQ_CLOSE, 6'd63);
      send_request(REQ_INIT, 6'd0);
      send_request(REQ_START, 6'd0);
      repeat (9) send_request(REQ_OPEN, 6'd0);
      send_request(REQ_CLOSE, 6'd3);
      send_request(REQ_CLOSE, 6'd3);
      send_request(REQ_OPEN, 6'd0);

      // Accelerator mode: init fails and drops ready, but open slots survive.
      apply_settings(1'b1, 4'd1, 4'd8);
      send_request(REQ_INIT, 6'd0);
      send_request(REQ_START, 6'd0);
      send_request(REQ_OPEN, 6'd0);
      send_request(REQ_CLOSE, 6'd3);

      // Saturated worker count and pool size; init clears the open slots.
      apply_settings(1'b0, 4'd15, 4'd15);
      send_request(REQ_INIT, 6'd0);
      repeat (3) send_request(REQ_OPEN, 6'd0);
      send_request(REQ_CLOSE, 6'd1);

      for (int p = 0; p < 10; p++) begin
         if (p < 8) begin
            nw  = 4'(ph_workers[p]);
            spw = 4'(ph_slots[p]);
            op  = ph_open[p];
         end else begin
            nw  = 4'($urandom_range(1, 8));
            spw = 4'($urandom_range(1, 8));
            op  = $urandom_range(35, 65);
         end
         apply_settings(ph_accel[p][0], nw, spw);
         send_request(REQ_INIT, 6'($urandom_range(63)));
         for (int k = 0; k < 60; k++) begin
            if (random_sent < 200) begin
               send_idle_pct = 12;
               recv_idle_pct = 66;
            end else if (random_sent < 400) begin
               send_idle_pct = 66;
               recv_idle_pct = 12;
            end else begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
            // Long response hold while requests keep coming.
            if (p == 1 && k == 20) rsp_hold_left = 150;
            // Sender pause until the block has answered everything.
            if (p == 2 && k == 30) drain_responses();
            random_request(op);
            random_sent++;
         end
      end

      drain_responses();
      repeat (20) @(posedge clock);
      $display("Ran %0d requests under %0d register settings; %0d responses checked.",
               sb.requests, settings_run, sb.checked);
      $display("Statuses: ok %0d, not initialized %0d, no idle %0d, invalid %0d, not open %0d.",
               sb.status_seen[STAT_OK], sb.status_seen[STAT_NOT_INIT],
               sb.status_seen[STAT_NO_IDLE], sb.status_seen[STAT_INVALID],
               sb.status_seen[STAT_NOT_OPEN]);
      if (sb.failures == 0) begin
         $display("session_pool_least_loaded_allocator_unit_tb: done, clean");
      end else begin
         $display("%0d mismatches in total", sb.failures);
         $display("session_pool_least_loaded_allocator_unit_tb: done, errors");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest correct run.
   initial begin
      #5_000_000;
      $display("Timed out with %0d responses pending.", sb.awaited.size());
      $display("session_pool_least_loaded_allocator_unit_tb: done, errors");
      $finish;
   end

endmodule

@@ session_pool_least_loaded_allocator_unit.f @@
rtl/spla_pkg.sv
rtl/spla_load.sv
rtl/spla_pool.sv
rtl/session_pool_least_loaded_allocator_unit.sv
rtl/spla_checker.sv
tb/sv/session_pool_least_loaded_allocator_unit_tb.sv
